/* src/tswg_pkg.sv */
// ----------------------------------------------------------------------------
// tswg_pkg
// Shared constants and types of the trapezoid speed wave generator.
// ----------------------------------------------------------------------------
package tswg_pkg;

    localparam int NUM_AXES = 4;

    // widths of the fields and registers
    localparam int TIME_W  = 32;
    localparam int LEN_W   = 16;
    localparam int AMP_W   = 15;
    localparam int SPEED_W = 16;
    localparam int CFG_W   = 32;
    localparam int IDX_W   = 3;

    // profile break points in ms
    localparam logic [LEN_W-1:0] RAMP_MS          = 16'd1000;
    localparam logic [LEN_W-1:0] HOLD_UP_END_MS   = 16'd3000;
    localparam logic [LEN_W-1:0] FALL_END_MS      = 16'd4000;
    localparam logic [LEN_W-1:0] NEG_RISE_END_MS  = 16'd5000;
    localparam logic [LEN_W-1:0] HOLD_DOWN_END_MS = 16'd7000;
    localparam logic [LEN_W-1:0] WAVE_END_MS      = 16'd8000;

    // ramp factor k in 0..1000
    localparam int K_W    = 10;
    localparam int PROD_W = AMP_W + K_W;     // amp * k
    localparam int QX_W   = PROD_W - 3;      // (amp * k) >> 3, then divide by 125
    localparam int RECIP_W = 24;
    localparam int RPROD_W = QX_W + RECIP_W;
    // ceil(2^30 / 125); exact floor division for every operand below 2^22
    localparam logic [RECIP_W-1:0] RECIP_M = 24'd8589935;
    localparam int RECIP_SHIFT = 30;

    // remainder unit: restoring steps, a few dividend bits per stage
    localparam int DIV_BITS   = 4;
    localparam int DIV_STAGES = TIME_W / DIV_BITS;

    typedef enum logic [IDX_W-1:0] {
        REG_START_TIME  = 3'd0,
        REG_CYCLE_LEN   = 3'd1,
        REG_AXIS_MASK   = 3'd2,
        REG_AMP_X1      = 3'd3,
        REG_AMP_X2      = 3'd4,
        REG_AMP_Y1      = 3'd5,
        REG_AMP_Y2      = 3'd6
    } t_cfg_idx;

    typedef logic signed [SPEED_W-1:0] t_speed;

endpackage

/* src/trapezoid_speed_wave_generator_top.sv */
// ----------------------------------------------------------------------------
// trapezoid_speed_wave_generator_top
// Four-axis trapezoidal speed set points from a millisecond time stamp.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------
//  input    | i_valid / o_stall    | i_now_time_ms
//  output   | o_valid / i_stall    | o_speed_x1, o_speed_x2, o_speed_y1, o_speed_y2
//  config   | i_cfg_wr_en          | i_cfg_index, i_cfg_wdata
//
//  One time stamp per cycle unless the output stalls; the stages are one subtract
//  stage, eight remainder stages of four restoring steps each, then segment select,
//  ramp multiply, reciprocal multiply for the divide by 1000 and the output register.
//  Synchronous active-low reset clears valid bits and loads register defaults.
//  A stall on a valid output freezes the whole pipeline; o_stall follows it.
// ----------------------------------------------------------------------------
module trapezoid_speed_wave_generator_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [tswg_pkg::TIME_W-1:0]         i_now_time_ms,
    output logic                                o_valid,
    input  logic                                i_stall,
    output tswg_pkg::t_speed                    o_speed_x1,
    output tswg_pkg::t_speed                    o_speed_x2,
    output tswg_pkg::t_speed                    o_speed_y1,
    output tswg_pkg::t_speed                    o_speed_y2,
    input  logic                                i_cfg_wr_en,
    input  logic [tswg_pkg::IDX_W-1:0]          i_cfg_index,
    input  logic [tswg_pkg::CFG_W-1:0]          i_cfg_wdata
);

    localparam int NA = tswg_pkg::NUM_AXES;
    localparam int NS = tswg_pkg::DIV_STAGES;

    // configuration registers
    logic [tswg_pkg::TIME_W-1:0] r_start;
    logic [tswg_pkg::LEN_W-1:0]  r_cycle_len;
    logic [NA-1:0]               r_mask;
    logic [tswg_pkg::AMP_W-1:0]  r_amp [NA];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start     <= '0;
            r_cycle_len <= tswg_pkg::WAVE_END_MS;
            r_mask      <= '1;
            for (int a = 0; a < NA; a++) begin
                r_amp[a] <= '0;
            end
        end else if (i_cfg_wr_en) begin
            unique case (tswg_pkg::t_cfg_idx'(i_cfg_index))
                tswg_pkg::REG_START_TIME: r_start     <= i_cfg_wdata;
                tswg_pkg::REG_CYCLE_LEN:  r_cycle_len <= i_cfg_wdata[tswg_pkg::LEN_W-1:0];
                tswg_pkg::REG_AXIS_MASK:  r_mask      <= i_cfg_wdata[NA-1:0];
                tswg_pkg::REG_AMP_X1:     r_amp[0]    <= i_cfg_wdata[tswg_pkg::AMP_W-1:0];
                tswg_pkg::REG_AMP_X2:     r_amp[1]    <= i_cfg_wdata[tswg_pkg::AMP_W-1:0];
                tswg_pkg::REG_AMP_Y1:     r_amp[2]    <= i_cfg_wdata[tswg_pkg::AMP_W-1:0];
                tswg_pkg::REG_AMP_Y2:     r_amp[3]    <= i_cfg_wdata[tswg_pkg::AMP_W-1:0];
                default: ;
            endcase
        end
    end

    // zero length behaves as one
    logic [tswg_pkg::LEN_W-1:0] w_len;
    assign w_len = (r_cycle_len == '0) ? tswg_pkg::LEN_W'(1) : r_cycle_len;

    // stage 0: elapsed time; stages 1..NS: remainder, dividend shifted left
    logic                           r_vld [NS+1];
    logic [tswg_pkg::LEN_W-1:0]     r_rem [NS+1];
    logic [tswg_pkg::TIME_W-1:0]    r_dif [NS+1];
    logic [tswg_pkg::LEN_W-1:0]     n_rem [NS+1];
    logic [tswg_pkg::TIME_W-1:0]    n_dif [NS+1];

    always_comb begin
        logic [tswg_pkg::LEN_W:0]   t;
        logic [tswg_pkg::LEN_W-1:0] rem;
        logic [tswg_pkg::TIME_W-1:0] dif;
        t   = '0;
        rem = '0;
        dif = '0;
        n_rem[0] = '0;
        n_dif[0] = i_now_time_ms - r_start;
        for (int s = 1; s <= NS; s++) begin
            rem = r_rem[s-1];
            dif = r_dif[s-1];
            for (int b = 0; b < tswg_pkg::DIV_BITS; b++) begin
                t = {rem, dif[tswg_pkg::TIME_W-1]};
                dif = {dif[tswg_pkg::TIME_W-2:0], 1'b0};
                if (t >= {1'b0, w_len}) begin
                    t = t - {1'b0, w_len};
                end
                rem = t[tswg_pkg::LEN_W-1:0];
            end
            n_rem[s] = rem;
            n_dif[s] = dif;
        end
    end

    // stage A: segment of the wave as ramp factor k (1000 on a hold) and sign
    logic                       r_a_vld;
    logic [tswg_pkg::K_W-1:0]   r_a_k;
    logic                       r_a_neg;
    logic [tswg_pkg::LEN_W-1:0] n_a_k;
    logic                       n_a_neg;
    logic [tswg_pkg::LEN_W-1:0] w_phase;

    assign w_phase = r_rem[NS];

    always_comb begin
        n_a_k   = '0;
        n_a_neg = 1'b0;
        priority if (w_phase < tswg_pkg::RAMP_MS) begin
            n_a_k = w_phase;
        end else if (w_phase < tswg_pkg::HOLD_UP_END_MS) begin
            n_a_k = tswg_pkg::RAMP_MS;
        end else if (w_phase < tswg_pkg::FALL_END_MS) begin
            n_a_k = tswg_pkg::FALL_END_MS - w_phase;
        end else if (w_phase < tswg_pkg::NEG_RISE_END_MS) begin
            n_a_k   = w_phase - tswg_pkg::FALL_END_MS;
            n_a_neg = 1'b1;
        end else if (w_phase < tswg_pkg::HOLD_DOWN_END_MS) begin
            n_a_k   = tswg_pkg::RAMP_MS;
            n_a_neg = 1'b1;
        end else if (w_phase < tswg_pkg::WAVE_END_MS) begin
            n_a_k   = tswg_pkg::WAVE_END_MS - w_phase;
            n_a_neg = 1'b1;
        end else begin
            n_a_k = '0;
        end
    end

    // stage B: amp * k; stage C: (amp * k >> 3) * ceil(2^30 / 125)
    logic                           r_b_vld;
    logic                           r_b_neg;
    logic [tswg_pkg::PROD_W-1:0]    r_b_prod [NA];
    logic                           r_c_vld;
    logic                           r_c_neg;
    logic [tswg_pkg::RPROD_W-1:0]   r_c_prod [NA];
    // stage D: sign, enable, output register
    logic                           r_d_vld;
    tswg_pkg::t_speed               r_d_spd [NA];

    // whole pipeline advances unless the output transaction is held
    logic w_adv;
    assign w_adv   = !(r_d_vld && i_stall);
    assign o_stall = r_d_vld && i_stall;

    logic [tswg_pkg::SPEED_W-1:0]   w_mag [NA];
    always_comb begin
        for (int a = 0; a < NA; a++) begin
            w_mag[a] = r_c_prod[a][tswg_pkg::RECIP_SHIFT +: tswg_pkg::SPEED_W];
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= NS; s++) begin
                r_vld[s] <= 1'b0;
            end
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
        end else if (w_adv) begin
            r_vld[0] <= i_valid;
            for (int s = 1; s <= NS; s++) begin
                r_vld[s] <= r_vld[s-1];
            end
            r_a_vld <= r_vld[NS];
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
            r_d_vld <= r_c_vld;
        end
    end

    // data path
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int s = 0; s <= NS; s++) begin
                r_rem[s] <= n_rem[s];
                r_dif[s] <= n_dif[s];
            end
            r_a_k   <= n_a_k[tswg_pkg::K_W-1:0];
            r_a_neg <= n_a_neg;
            r_b_neg <= r_a_neg;
            r_c_neg <= r_b_neg;
            for (int a = 0; a < NA; a++) begin
                r_b_prod[a] <= {{tswg_pkg::K_W{1'b0}}, r_amp[a]}
                             * {{tswg_pkg::AMP_W{1'b0}}, r_a_k};
                r_c_prod[a] <= {{tswg_pkg::RECIP_W{1'b0}}, r_b_prod[a][tswg_pkg::PROD_W-1:3]}
                             * {{tswg_pkg::QX_W{1'b0}}, tswg_pkg::RECIP_M};
                if (!r_mask[a]) begin
                    r_d_spd[a] <= '0;
                end else if (r_c_neg) begin
                    r_d_spd[a] <= tswg_pkg::t_speed'(-w_mag[a]);
                end else begin
                    r_d_spd[a] <= tswg_pkg::t_speed'(w_mag[a]);
                end
            end
        end
    end

    assign o_valid    = r_d_vld;
    assign o_speed_x1 = r_d_spd[0];
    assign o_speed_x2 = r_d_spd[1];
    assign o_speed_y1 = r_d_spd[2];
    assign o_speed_y2 = r_d_spd[3];

endmodule
